FILE: rtl/tcgr_pkg.sv
// Shared types, constants and helper functions of the text console glyph renderer.
package tcgr_pkg;

  localparam int MAX_RESULTS   = 22;
  localparam int FALLBACK_SLOT = 63;
  localparam int PUNCT_ADVANCE = 5;
  localparam int PERIOD_ROW    = 7;
  localparam int GADDR_W       = 11;
  localparam logic [7:0] DOT_MASK   = 8'h06;
  localparam logic [7:0] CODE_PERIOD  = 8'h2E;
  localparam logic [7:0] CODE_COLON   = 8'h3A;
  localparam logic [7:0] CODE_NEWLINE = 8'h0A;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_PRINT = 2'd1,
    MODE_HOME  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_PRINT = 2'd1,
    OP_HOME  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CLS_GLYPH   = 2'd0,
    CLS_PERIOD  = 2'd1,
    CLS_COLON   = 2'd2,
    CLS_NEWLINE = 2'd3
  } cls_t;

  typedef enum logic [2:0] {
    B_IDLE   = 3'd0,
    B_ERASE  = 3'd1,
    B_GLYPH  = 3'd2,
    B_DOTS   = 3'd3,
    B_ADV    = 3'd4,
    B_SCROLL = 3'd5,
    B_CURSOR = 3'd6,
    B_DONE   = 3'd7
  } bstate_t;

  typedef enum logic [3:0] {
    CFG_WINDOW_WIDTH  = 4'd0,
    CFG_WINDOW_HEIGHT = 4'd1,
    CFG_START_COLUMN  = 4'd2,
    CFG_START_LINE    = 4'd3,
    CFG_ROW_PITCH     = 4'd4,
    CFG_FONT_COLOR    = 4'd5,
    CFG_BG_COLOR      = 4'd6,
    CFG_FONT_FLAGS    = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [6:0] glyph_slot;
    logic [2:0] glyph_row;
    logic [7:0] glyph_bits;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] row_offset;
    logic [7:0]  byte_mask;
    logic [63:0] pixel_bytes;
    logic        last;
  } res_t;

  typedef struct packed {
    op_t                op;
    cls_t               cls;
    logic [GADDR_W-1:0] addr;
    logic [7:0]         bits;
  } cmd_t;

  typedef struct packed {
    logic [11:0] window_width;
    logic [11:0] window_height;
    logic [11:0] start_column;
    logic [11:0] start_line;
    logic [11:0] row_pitch;
    logic [7:0]  font_color;
    logic [7:0]  background_color;
    logic [2:0]  font_flags;
  } cfg_t;

  function automatic logic [63:0] fill_bytes(input logic [7:0] color, input logic [7:0] mask);
    logic [63:0] v;
    v = '0;
    for (int j = 0; j < 8; j++) begin
      if (mask[j]) v[8*j +: 8] = color;
    end
    return v;
  endfunction

  // colon dots sit on rows 1, 2, 5, 6
  function automatic logic [2:0] colon_row(input logic [1:0] idx);
    logic [2:0] r;
    case (idx)
      2'd0:    r = 3'd1;
      2'd1:    r = 3'd2;
      2'd2:    r = 3'd5;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/tcgr_front.sv
// Front end: classifies requests and queues valid ones for the back end.
module tcgr_front #(
  parameter int GLYPH_HEIGHT = 8,
  parameter int GLYPH_SLOTS  = 78
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  tcgr_pkg::item_t item,
  output logic           q_valid,
  input  logic           q_pop,
  output tcgr_pkg::cmd_t q_cmd
);

  tcgr_pkg::cmd_t q_mem [2];
  logic           wp, rp;
  logic [1:0]     count;

  tcgr_pkg::cmd_t cmd;
  logic           keep;
  logic           push;
  logic [6:0]     slot;

  always_comb begin
    slot = 7'(tcgr_pkg::FALLBACK_SLOT);
    if (item.char_code >= 8'h41 && item.char_code <= 8'h5A)
      slot = 7'(item.char_code - 8'h41);
    else if (item.char_code >= 8'h61 && item.char_code <= 8'h7A)
      slot = 7'(item.char_code - 8'h61 + 8'd26);
    else if (item.char_code >= 8'h30 && item.char_code <= 8'h39)
      slot = 7'(item.char_code - 8'h30 + 8'd52);
  end

  always_comb begin
    cmd      = '0;
    cmd.bits = item.glyph_bits;
    keep     = 1'b0;
    unique case (tcgr_pkg::mode_t'(item.mode))
      tcgr_pkg::MODE_LOAD: begin
        cmd.op   = tcgr_pkg::OP_LOAD;
        cmd.addr = tcgr_pkg::GADDR_W'(item.glyph_slot) * tcgr_pkg::GADDR_W'(GLYPH_HEIGHT)
                 + tcgr_pkg::GADDR_W'(item.glyph_row);
        keep     = (int'(item.glyph_slot) < GLYPH_SLOTS) && (int'(item.glyph_row) < GLYPH_HEIGHT);
      end
      tcgr_pkg::MODE_PRINT: begin
        cmd.op   = tcgr_pkg::OP_PRINT;
        cmd.addr = tcgr_pkg::GADDR_W'(slot) * tcgr_pkg::GADDR_W'(GLYPH_HEIGHT);
        keep     = 1'b1;
        if (item.char_code == tcgr_pkg::CODE_PERIOD)       cmd.cls = tcgr_pkg::CLS_PERIOD;
        else if (item.char_code == tcgr_pkg::CODE_COLON)   cmd.cls = tcgr_pkg::CLS_COLON;
        else if (item.char_code == tcgr_pkg::CODE_NEWLINE) cmd.cls = tcgr_pkg::CLS_NEWLINE;
        else                                               cmd.cls = tcgr_pkg::CLS_GLYPH;
      end
      tcgr_pkg::MODE_HOME: begin
        cmd.op = tcgr_pkg::OP_HOME;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall && keep;
  assign q_valid    = (count != 2'd0);
  assign q_cmd      = q_mem[rp];

  always_ff @(posedge clk) begin
    if (push) q_mem[wp] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/tcgr_back.sv
// Back end: print sequencer, glyph store and result output stage.
module tcgr_back #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 8,
  parameter int GLYPH_SLOTS  = 78
) (
  input  logic           clk,
  input  logic           rst,
  input  tcgr_pkg::cfg_t cfg,
  input  logic           q_valid,
  output logic           q_pop,
  input  tcgr_pkg::cmd_t q_cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output tcgr_pkg::res_t res
);

  localparam int DEPTH = GLYPH_SLOTS * GLYPH_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(GLYPH_HEIGHT);
  localparam logic [7:0] FULL = 8'((1 << GLYPH_WIDTH) - 1);
  localparam logic [AW-1:0] FALLBACK_BASE = AW'(tcgr_pkg::FALLBACK_SLOT * GLYPH_HEIGHT);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;

  tcgr_pkg::bstate_t state, state_next;
  logic [KW-1:0] k, k_next;
  logic [11:0]   cx, cx_next, cy, cy_next;
  tcgr_pkg::cls_t cls, cls_next;
  logic [AW-1:0] base, base_next;
  logic          nested, nested_next;
  logic [4:0]    cnt;
  logic          pend_v, out_v;
  tcgr_pkg::res_t pend, out_data, out_load;

  logic          out_free, room, drop, want, go, push, done_move;
  logic          rd_en, mem_we;
  logic [AW-1:0] rd_addr;
  logic [12:0]   rowv;
  logic [7:0]    mask;
  logic [63:0]   pix;
  logic          scroll_kind;
  tcgr_pkg::res_t res_new;
  logic [12:0]   x_adv_w, y_adv;
  logic [11:0]   x_adv;
  logic          wrap_hit, scroll_hit;
  logic [24:0]   prod;

  assign out_free = !out_v || !res_stall;
  assign room     = !pend_v || out_free;
  assign drop     = (cnt >= 5'(tcgr_pkg::MAX_RESULTS));
  assign go       = !want || drop || room;
  assign push     = want && !drop && room;

  // cursor advance, wrap test and scroll test
  always_comb begin
    y_adv = {1'b0, cy};
    if (cls == tcgr_pkg::CLS_NEWLINE) begin
      x_adv = cfg.start_column;
      y_adv = {1'b0, cy} + 13'(GLYPH_HEIGHT);
    end else if (cls == tcgr_pkg::CLS_PERIOD || cls == tcgr_pkg::CLS_COLON) begin
      x_adv = cx + 12'(tcgr_pkg::PUNCT_ADVANCE);
    end else begin
      x_adv = cx + 12'(GLYPH_WIDTH);
    end
    x_adv_w    = {1'b0, x_adv} + 13'(GLYPH_WIDTH);
    wrap_hit   = x_adv_w >= {1'b0, cfg.window_width};
    scroll_hit = ({1'b0, cy} + 13'(GLYPH_HEIGHT)) >= {1'b0, cfg.window_height};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcgr_pkg::B_IDLE:
        if (q_valid && q_cmd.op == tcgr_pkg::OP_PRINT) state_next = tcgr_pkg::B_ERASE;
      tcgr_pkg::B_ERASE:
        if (go) begin
          if (cls == tcgr_pkg::CLS_PERIOD || cls == tcgr_pkg::CLS_COLON)
            state_next = tcgr_pkg::B_DOTS;
          else
            state_next = tcgr_pkg::B_GLYPH;
        end
      tcgr_pkg::B_GLYPH:
        if (go && k == KW'(GLYPH_HEIGHT - 1)) state_next = tcgr_pkg::B_ADV;
      tcgr_pkg::B_DOTS:
        if (go && (cls == tcgr_pkg::CLS_PERIOD || k[1:0] == 2'd3)) state_next = tcgr_pkg::B_ADV;
      tcgr_pkg::B_ADV:
        if (wrap_hit && cfg.font_flags[0] && !nested) state_next = tcgr_pkg::B_ERASE;
        else                                            state_next = tcgr_pkg::B_SCROLL;
      tcgr_pkg::B_SCROLL:
        if (go) state_next = tcgr_pkg::B_CURSOR;
      tcgr_pkg::B_CURSOR:
        if (go) state_next = nested ? tcgr_pkg::B_SCROLL : tcgr_pkg::B_DONE;
      tcgr_pkg::B_DONE:
        if (out_free) state_next = tcgr_pkg::B_IDLE;
      default: state_next = tcgr_pkg::B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    want        = 1'b0;
    rowv        = {1'b0, cy};
    mask        = FULL;
    pix         = '0;
    scroll_kind = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = base;
    mem_we      = 1'b0;
    q_pop       = 1'b0;
    done_move   = 1'b0;
    k_next      = k;
    cx_next     = cx;
    cy_next     = cy;
    cls_next    = cls;
    base_next   = base;
    nested_next = nested;
    unique case (state)
      tcgr_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.op)
            tcgr_pkg::OP_LOAD: mem_we = 1'b1;
            tcgr_pkg::OP_HOME: begin
              cx_next = cfg.start_column;
              cy_next = cfg.start_line;
            end
            default: begin
              cls_next    = q_cmd.cls;
              base_next   = q_cmd.addr[AW-1:0];
              nested_next = 1'b0;
            end
          endcase
        end
      end
      tcgr_pkg::B_ERASE: begin
        want  = 1'b1;
        rowv  = {1'b0, cy} + 13'(GLYPH_HEIGHT - 2);
        rd_en = go;
        k_next = '0;
      end
      tcgr_pkg::B_GLYPH: begin
        want = 1'b1;
        rowv = {1'b0, cy} + 13'(k);
        for (int j = 0; j < 8; j++) begin
          if (FULL[j]) pix[8*j +: 8] = rdata[j] ? cfg.font_color : cfg.background_color;
        end
        rd_en   = go;
        rd_addr = base + AW'(k) + AW'(1);
        if (go) k_next = k + KW'(1);
      end
      tcgr_pkg::B_DOTS: begin
        want = 1'b1;
        mask = tcgr_pkg::DOT_MASK;
        pix  = tcgr_pkg::fill_bytes(cfg.font_color, tcgr_pkg::DOT_MASK);
        if (cls == tcgr_pkg::CLS_PERIOD) rowv = {1'b0, cy} + 13'(tcgr_pkg::PERIOD_ROW);
        else                             rowv = {1'b0, cy} + 13'(tcgr_pkg::colon_row(k[1:0]));
        if (go) k_next = k + KW'(1);
      end
      tcgr_pkg::B_ADV: begin
        cy_next = y_adv[11:0];
        cx_next = x_adv;
        if (wrap_hit) begin
          if (cfg.font_flags[0] && !nested) begin
            nested_next = 1'b1;
            cls_next    = tcgr_pkg::CLS_NEWLINE;
            base_next   = FALLBACK_BASE;
          end else begin
            cx_next = x_adv - 12'(GLYPH_WIDTH);
          end
        end
      end
      tcgr_pkg::B_SCROLL: begin
        want        = scroll_hit && cfg.font_flags[1];
        scroll_kind = 1'b1;
        // hold the cursor until the scroll request has a slot or is dropped at the cap
        if (scroll_hit && go) cy_next = cy - 12'(GLYPH_HEIGHT);
      end
      tcgr_pkg::B_CURSOR: begin
        want = cfg.font_flags[2];
        rowv = {1'b0, cy} + 13'(GLYPH_HEIGHT - 2);
        pix  = tcgr_pkg::fill_bytes(cfg.font_color, FULL);
        if (go && nested) nested_next = 1'b0;
      end
      tcgr_pkg::B_DONE: done_move = out_free;
      default: ;
    endcase
  end

  always_comb begin
    prod    = 25'(rowv) * 25'(cfg.row_pitch);
    res_new = '0;
    if (scroll_kind) begin
      res_new.kind = 1'b1;
    end else begin
      res_new.row_offset  = prod[23:0] + 24'(cx);
      res_new.byte_mask   = mask;
      res_new.pixel_bytes = pix;
    end
  end

  // held result moving to the output; it is the final one when the print finishes
  always_comb begin
    out_load      = pend;
    out_load.last = done_move;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[q_cmd.addr[AW-1:0]] <= q_cmd.bits;
    if (rd_en)  rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    k      <= k_next;
    cls    <= cls_next;
    base   <= base_next;
    if (push) pend <= res_new;
    if ((push && pend_v) || done_move) out_data <= out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= tcgr_pkg::B_IDLE;
      cx     <= '0;
      cy     <= '0;
      nested <= 1'b0;
      cnt    <= '0;
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      state  <= state_next;
      cx     <= cx_next;
      cy     <= cy_next;
      nested <= nested_next;
      if (state == tcgr_pkg::B_IDLE) cnt <= '0;
      else if (push)                 cnt <= cnt + 5'd1;
      if ((push && pend_v) || done_move) out_v <= 1'b1;
      else if (!res_stall)               out_v <= 1'b0;
      if (push)           pend_v <= 1'b1;
      else if (done_move) pend_v <= 1'b0;
    end
  end

  assign res_valid = out_v;
  assign res       = out_data;

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == tcgr_pkg::B_IDLE |-> !pend_v)
    else $error("pending result left over in idle");
  a_done_pend: assert property (@(posedge clk) disable iff (rst)
    state == tcgr_pkg::B_DONE |-> pend_v)
    else $error("finish without a held result");
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= 5'(tcgr_pkg::MAX_RESULTS))
    else $error("result count past cap");
  a_nested_scope: assert property (@(posedge clk) disable iff (rst)
    nested |-> (state != tcgr_pkg::B_IDLE && state != tcgr_pkg::B_DONE))
    else $error("nested newline outside a print");

endmodule

FILE: rtl/text_console_glyph_renderer.sv
// Top level of the text console glyph renderer: config registers, front end, back end.
//
//  channel | direction | handshake              | payload
//  item    | in        | item_valid / item_stall | item   (tcgr_pkg::item_t)
//  res     | out       | res_valid / res_stall   | res    (tcgr_pkg::res_t)
//  cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A print request steps through erase, one row per glyph store read (dot rows for
// a period or colon), advance, scroll, cursor, finish; flag 0 nests a newline on wrap.
// Load and home are carried out in the idle state as they leave the queue.
// The glyph store's single read port sets a pace of one row per cycle unless stalled.
// rst is synchronous: cursor to 0, registers to defaults, queue and output empty.
// A two-entry queue lets requests arrive while a print drains into a stalled output.
module text_console_glyph_renderer #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 8,
  parameter int GLYPH_SLOTS  = 78
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  tcgr_pkg::item_t item,
  output logic            res_valid,
  input  logic            res_stall,
  output tcgr_pkg::res_t  res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_index,
  input  logic [11:0]     cfg_data
);

  tcgr_pkg::cfg_t cfg;
  logic           q_valid, q_pop;
  tcgr_pkg::cmd_t q_cmd;

  // registers always accept a write; the user writes only while idle, nothing checks it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_width     <= 12'd320;
      cfg.window_height    <= 12'd200;
      cfg.start_column     <= 12'd0;
      cfg.start_line       <= 12'd0;
      cfg.row_pitch        <= 12'd320;
      cfg.font_color       <= 8'd15;
      cfg.background_color <= 8'd0;
      cfg.font_flags       <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tcgr_pkg::cfg_idx_t'(cfg_index))
        tcgr_pkg::CFG_WINDOW_WIDTH:  cfg.window_width     <= cfg_data;
        tcgr_pkg::CFG_WINDOW_HEIGHT: cfg.window_height    <= cfg_data;
        tcgr_pkg::CFG_START_COLUMN:  cfg.start_column     <= cfg_data;
        tcgr_pkg::CFG_START_LINE:    cfg.start_line       <= cfg_data;
        tcgr_pkg::CFG_ROW_PITCH:     cfg.row_pitch        <= cfg_data;
        tcgr_pkg::CFG_FONT_COLOR:    cfg.font_color       <= cfg_data[7:0];
        tcgr_pkg::CFG_BG_COLOR:      cfg.background_color <= cfg_data[7:0];
        tcgr_pkg::CFG_FONT_FLAGS:    cfg.font_flags       <= cfg_data[2:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // front: classify request, pick glyph slot, queue it
  tcgr_front #(
    .GLYPH_HEIGHT(GLYPH_HEIGHT),
    .GLYPH_SLOTS (GLYPH_SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd)
  );

  // back: glyph store, cursor, row write sequencer, output stage
  tcgr_back #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .GLYPH_HEIGHT(GLYPH_HEIGHT),
    .GLYPH_SLOTS (GLYPH_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

endmodule

FILE: bench/tb_render_checker.sv
// Predictor and result checker for the glyph renderer channels.
module tb_render_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            item_stall,
  input  tcgr_pkg::item_t item,
  input  logic            res_valid,
  input  logic            res_stall,
  input  tcgr_pkg::res_t  res,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [3:0]      cfg_index,
  input  logic [11:0]     cfg_data,
  output int              errors,
  output int              pending,
  output int              results_seen
);

  localparam int GW = 8;
  localparam int GH = 8;
  localparam int SLOTS = 78;

  tcgr_pkg::cfg_t regs;
  logic [11:0]    cur_x, cur_y;
  logic [7:0]     glyphs [SLOTS*GH];
  tcgr_pkg::res_t expected_rows [$];

  task automatic report(input string what, input tcgr_pkg::res_t got,
                        input tcgr_pkg::res_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] fill(input logic [7:0] color, input logic [7:0] mask);
    logic [63:0] v;
    v = '0;
    for (int j = 0; j < 8; j++) if (mask[j]) v[8*j +: 8] = color;
    return v;
  endfunction

  // row is the unwrapped pixel row: cursor y plus the row within the glyph
  task automatic push_row(input logic [12:0] row, input logic [7:0] mask,
                          input logic [63:0] pix);
    tcgr_pkg::res_t r;
    r.kind = 1'b0;
    r.row_offset = 24'(cur_x) + 24'(row) * 24'(regs.row_pitch);
    r.byte_mask = mask;
    r.pixel_bytes = pix;
    r.last = 1'b0;
    expected_rows.push_back(r);
  endtask

  task automatic print_char(input logic [7:0] code, input bit may_wrap);
    int slot;
    logic [7:0] bits;
    logic [63:0] pix;
    tcgr_pkg::res_t sc;
    push_row(13'(cur_y) + 13'(GH - 2), 8'hFF, '0);
    if (code == tcgr_pkg::CODE_PERIOD) begin
      push_row(13'(cur_y) + 13'd7, tcgr_pkg::DOT_MASK,
               fill(regs.font_color, tcgr_pkg::DOT_MASK));
    end else if (code == tcgr_pkg::CODE_COLON) begin
      push_row(13'(cur_y) + 13'd1, tcgr_pkg::DOT_MASK,
               fill(regs.font_color, tcgr_pkg::DOT_MASK));
      push_row(13'(cur_y) + 13'd2, tcgr_pkg::DOT_MASK,
               fill(regs.font_color, tcgr_pkg::DOT_MASK));
      push_row(13'(cur_y) + 13'd5, tcgr_pkg::DOT_MASK,
               fill(regs.font_color, tcgr_pkg::DOT_MASK));
      push_row(13'(cur_y) + 13'd6, tcgr_pkg::DOT_MASK,
               fill(regs.font_color, tcgr_pkg::DOT_MASK));
    end else begin
      if (code >= "A" && code <= "Z") slot = code - "A";
      else if (code >= "a" && code <= "z") slot = 26 + code - "a";
      else if (code >= "0" && code <= "9") slot = 52 + code - "0";
      else slot = tcgr_pkg::FALLBACK_SLOT;
      for (int i = 0; i < GH; i++) begin
        bits = glyphs[slot*GH + i];
        for (int j = 0; j < 8; j++)
          pix[8*j +: 8] = bits[j] ? regs.font_color : regs.background_color;
        push_row(13'(cur_y) + 13'(i), 8'hFF, pix);
      end
    end
    if (code == tcgr_pkg::CODE_NEWLINE) begin
      cur_x = regs.start_column;
      cur_y = cur_y + 12'(GH);
    end else if (code == tcgr_pkg::CODE_PERIOD || code == tcgr_pkg::CODE_COLON) begin
      cur_x = cur_x + 12'(tcgr_pkg::PUNCT_ADVANCE);
    end else begin
      cur_x = cur_x + 12'(GW);
    end
    if (13'(cur_x) + 13'(GW) >= 13'(regs.window_width)) begin
      if (regs.font_flags[0] && may_wrap) print_char(tcgr_pkg::CODE_NEWLINE, 1'b0);
      else cur_x = cur_x - 12'(GW);
    end
    if (13'(cur_y) + 13'(GH) >= 13'(regs.window_height)) begin
      if (regs.font_flags[1]) begin
        sc = '0;
        sc.kind = 1'b1;
        expected_rows.push_back(sc);
      end
      cur_y = cur_y - 12'(GH);
    end
    if (regs.font_flags[2])
      push_row(13'(cur_y) + 13'(GH - 2), 8'hFF, fill(regs.font_color, 8'hFF));
  endtask

  task automatic predict(input tcgr_pkg::item_t it);
    int prior_count;
    tcgr_pkg::res_t r;
    prior_count = expected_rows.size();
    case (it.mode)
      tcgr_pkg::MODE_LOAD:
        if (it.glyph_slot < SLOTS) glyphs[it.glyph_slot*GH + it.glyph_row] = it.glyph_bits;
      tcgr_pkg::MODE_PRINT: print_char(it.char_code, 1'b1);
      tcgr_pkg::MODE_HOME: begin
        cur_x = regs.start_column;
        cur_y = regs.start_line;
      end
      default: ;
    endcase
    if (expected_rows.size() > prior_count) begin
      r = expected_rows.pop_back();
      r.last = 1'b1;
      expected_rows.push_back(r);
    end
  endtask

  assign pending = expected_rows.size();

  always @(posedge clk) begin
    tcgr_pkg::res_t want;
    if (rst) begin
      regs <= '{12'd320, 12'd200, 12'd0, 12'd0, 12'd320, 8'd15, 8'd0, 3'd0};
      cur_x = '0;
      cur_y = '0;
      errors = 0;
      results_seen = 0;
      expected_rows.delete();
    end else begin
      if (res_valid && !res_stall) begin
        results_seen++;
        if (expected_rows.size() == 0) begin
          report("unexpected", res, '0);
        end else begin
          want = expected_rows.pop_front();
          if (res.kind !== want.kind) report("kind", res, want);
          else if (res.row_offset !== want.row_offset) report("row_offset", res, want);
          else if (res.byte_mask !== want.byte_mask) report("byte_mask", res, want);
          else if (res.pixel_bytes !== want.pixel_bytes) report("pixel_bytes", res, want);
          else if (res.last !== want.last) report("last", res, want);
        end
      end
      if (item_valid && !item_stall) predict(item);
      if (cfg_valid && cfg_ready) begin
        case (tcgr_pkg::cfg_idx_t'(cfg_index))
          tcgr_pkg::CFG_WINDOW_WIDTH:  regs.window_width <= cfg_data;
          tcgr_pkg::CFG_WINDOW_HEIGHT: regs.window_height <= cfg_data;
          tcgr_pkg::CFG_START_COLUMN:  regs.start_column <= cfg_data;
          tcgr_pkg::CFG_START_LINE:    regs.start_line <= cfg_data;
          tcgr_pkg::CFG_ROW_PITCH:     regs.row_pitch <= cfg_data;
          tcgr_pkg::CFG_FONT_COLOR:    regs.font_color <= cfg_data[7:0];
          tcgr_pkg::CFG_BG_COLOR:      regs.background_color <= cfg_data[7:0];
          tcgr_pkg::CFG_FONT_FLAGS:    regs.font_flags <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: bench/tb.sv
// Stimulus, idling control and verdict for the glyph renderer bench.
module tb;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_stall;
  tcgr_pkg::item_t item = '0;
  logic            res_valid;
  logic            res_stall = 1'b0;
  tcgr_pkg::res_t  res;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [3:0]      cfg_index = '0;
  logic [11:0]     cfg_data = '0;
  int              errors, pending, results_seen;

  // idle percentages for sender and receiver, changed per phase
  int send_idle = 0;
  int recv_idle = 0;
  int idle_cycles = 0;
  int printed = 0;
  localparam int WATCHDOG = 20000;
  // glyph slots that are loaded and printed: A-D, a-d, 0-1 and the fallback
  localparam int USED_SLOTS = 11;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  text_console_glyph_renderer dut (
    .clk, .rst, .item_valid, .item_stall, .item, .res_valid, .res_stall, .res,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tb_render_checker checker_i (
    .clk, .rst, .item_valid, .item_stall, .item, .res_valid, .res_stall, .res,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending, .results_seen
  );

  // receiver stalls at random, redrawn every cycle
  always @(posedge clk) res_stall <= ($urandom_range(99) < recv_idle);

  // watchdog: cycles in which no request, result or config write is taken
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= WATCHDOG) begin
      $display("tb: watchdog expired, %0d results outstanding", pending);
      $display("tb: errors");
      $finish;
    end
  end

  // valid stays up after the accepting edge so requests can run back to back;
  // a register write or drain takes it down, as does a send that idles first
  task automatic send(input tcgr_pkg::item_t it);
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (it.mode == tcgr_pkg::MODE_PRINT) printed++;
  endtask

  task automatic load(input int slot, input int row, input logic [7:0] bits);
    tcgr_pkg::item_t it;
    it = '0;
    it.mode = tcgr_pkg::MODE_LOAD;
    it.glyph_slot = 7'(slot);
    it.glyph_row = 3'(row);
    it.glyph_bits = bits;
    send(it);
  endtask

  task automatic put_char(input logic [7:0] code);
    tcgr_pkg::item_t it;
    it = tcgr_pkg::item_t'(28'($urandom()));
    it.mode = tcgr_pkg::MODE_PRINT;
    it.char_code = code;
    send(it);
  endtask

  task automatic home();
    tcgr_pkg::item_t it;
    it = tcgr_pkg::item_t'(28'($urandom()));
    it.mode = tcgr_pkg::MODE_HOME;
    send(it);
  endtask

  // registers change only once all results are in and the block has settled
  task automatic drain();
    item_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input tcgr_pkg::cfg_idx_t idx, input logic [11:0] value);
    item_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_window(input logic [11:0] w, input logic [11:0] h,
                            input logic [2:0] flags);
    write_reg(tcgr_pkg::CFG_WINDOW_WIDTH, w);
    write_reg(tcgr_pkg::CFG_WINDOW_HEIGHT, h);
    write_reg(tcgr_pkg::CFG_FONT_FLAGS, 12'(flags));
  endtask

  function automatic int slot_of(input int idx);
    if (idx < 4) return idx;
    if (idx < 8) return 26 + idx - 4;
    if (idx < 10) return 52 + idx - 8;
    return tcgr_pkg::FALLBACK_SLOT;
  endfunction

  // printable codes from the loaded slots, some newline and punctuation,
  // rest any code that is not a letter or digit
  function automatic logic [7:0] pick_code();
    int r;
    logic [7:0] c;
    r = $urandom_range(99);
    if (r < 30) return 8'("A" + $urandom_range(3));
    if (r < 55) return 8'("a" + $urandom_range(3));
    if (r < 68) return 8'("0" + $urandom_range(1));
    if (r < 76) return tcgr_pkg::CODE_PERIOD;
    if (r < 84) return tcgr_pkg::CODE_COLON;
    if (r < 90) return tcgr_pkg::CODE_NEWLINE;
    c = 8'($urandom_range(255));
    while ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9"))
      c = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic random_phase(input int count);
    tcgr_pkg::item_t it;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 78) begin
        put_char(pick_code());
      end else if (r < 90) begin
        load(slot_of($urandom_range(USED_SLOTS - 1)), $urandom_range(7),
             8'($urandom_range(255)));
      end else if (r < 95) begin
        home();
      end else begin
        // noise: bad slots and the unused mode, which the block ignores
        it = tcgr_pkg::item_t'(28'($urandom()));
        if (it.mode == tcgr_pkg::MODE_LOAD) it.glyph_slot = 7'($urandom_range(78, 127));
        else it.mode = tcgr_pkg::MODE_NONE;
        send(it);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every row of the glyphs in use written before any print
    for (int s = 0; s < USED_SLOTS; s++)
      for (int r = 0; r < 8; r++)
        load(slot_of(s), r, 8'($urandom_range(255)));
    load(0, 0, 8'h00);
    load(77, 7, 8'hFF);
    load(63, 3, 8'hA5);
    drain();

    // directed: each character class, font color at its maximum, flags varied
    write_reg(tcgr_pkg::CFG_FONT_COLOR, 12'hFFF);
    write_reg(tcgr_pkg::CFG_BG_COLOR, 12'h0AA);
    write_reg(tcgr_pkg::CFG_ROW_PITCH, 12'd4095);
    write_reg(tcgr_pkg::CFG_START_COLUMN, 12'd4);
    write_reg(tcgr_pkg::CFG_START_LINE, 12'd16);
    set_window(12'd40, 12'd40, 3'd7);
    put_char("A");
    put_char("d");
    put_char("1");
    put_char(tcgr_pkg::CODE_PERIOD);
    put_char(tcgr_pkg::CODE_COLON);
    put_char(tcgr_pkg::CODE_NEWLINE);
    put_char(8'hFF);
    put_char(8'h00);
    put_char("C");
    put_char("C");
    home();
    load(100, 2, 8'h3C);
    begin
      tcgr_pkg::item_t it;
      it = '0;
      it.mode = tcgr_pkg::MODE_NONE;
      send(it);
    end
    drain();
    // zero-size window: every print wraps and scrolls
    set_window(12'd0, 12'd0, 3'd3);
    put_char("B");
    put_char(tcgr_pkg::CODE_NEWLINE);
    drain();
    set_window(12'd4095, 12'd4095, 3'd4);
    write_reg(tcgr_pkg::CFG_ROW_PITCH, 12'd1);
    write_reg(tcgr_pkg::CFG_START_COLUMN, 12'd4095);
    write_reg(tcgr_pkg::CFG_START_LINE, 12'd4095);
    home();
    put_char("b");
    put_char(tcgr_pkg::CODE_COLON);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 74; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 74; end
        default: begin send_idle = 9; recv_idle = 9; end
      endcase
      write_reg(tcgr_pkg::CFG_ROW_PITCH, 12'($urandom_range(1, 4095)));
      write_reg(tcgr_pkg::CFG_FONT_COLOR, 12'($urandom_range(255)));
      write_reg(tcgr_pkg::CFG_BG_COLOR, 12'($urandom_range(255)));
      write_reg(tcgr_pkg::CFG_START_COLUMN, 12'($urandom_range(ph < 4 ? 40 : 4095)));
      write_reg(tcgr_pkg::CFG_START_LINE, 12'($urandom_range(ph < 4 ? 40 : 4095)));
      set_window(12'($urandom_range(ph < 6 ? 160 : 4095)),
                 12'($urandom_range(ph < 6 ? 120 : 4095)), 3'($urandom_range(7)));
      home();
      random_phase(32);
      drain();
    end
    send_idle = 0;
    recv_idle = 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("tb: %0d characters printed, %0d results checked", printed, results_seen);
    $display("tb: covered glyph loads, punctuation, newline, wrap, scroll and home");
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end
endmodule

FILE: text_console_glyph_renderer.f
rtl/tcgr_pkg.sv
rtl/tcgr_front.sv
rtl/tcgr_back.sv
rtl/text_console_glyph_renderer.sv
bench/tb_render_checker.sv
bench/tb.sv
